[rtl/tsp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tsp_pkg;

   // Table geometry.
   localparam int STEP_DEPTH = 64;
   localparam int IDX_W      = $clog2(STEP_DEPTH);
   localparam int LEN_W      = $clog2(STEP_DEPTH + 1);

   // Field widths of the request and response payloads.
   localparam int MODE_W     = 3;
   localparam int ENTRY_W    = 6;
   localparam int FREQ_W     = 16;
   localparam int DUR_W      = 16;
   localparam int SEQ_LEN_W  = 8;
   localparam int TEMPO_W    = 16;
   localparam int STEP_OUT_W = 6;

   // Packed table entry: frequency in the high half, duration in the low half.
   localparam int ENTRY_DATA_W = FREQ_W + DUR_W;

   // Scaled duration arithmetic.
   localparam int PROD_W    = DUR_W + TEMPO_W;
   localparam int DIV_STEPS = PROD_W;
   localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

   // Reset values of the tempo fraction.
   localparam logic [TEMPO_W-1:0] TEMPO_NUM_RST = TEMPO_W'(5);
   localparam logic [TEMPO_W-1:0] TEMPO_DEN_RST = TEMPO_W'(6);

   // Request operation codes.
   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD   = 3'd0,
      MODE_PLAY   = 3'd1,
      MODE_STOP   = 3'd2,
      MODE_TICK   = 3'd3,
      MODE_ENABLE = 3'd4
   } mode_type;

endpackage

`default_nettype wire

[rtl/tsp_channels.sv]
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one command to the player.
interface tsp_req_if;
   import tsp_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [MODE_W-1:0]    mode;
   logic [ENTRY_W-1:0]   entry_index;
   logic [FREQ_W-1:0]    entry_freq;
   logic [DUR_W-1:0]     entry_duration;
   logic [SEQ_LEN_W-1:0] seq_length;
   logic [TEMPO_W-1:0]   tempo_num;
   logic [TEMPO_W-1:0]   tempo_den;
   logic                 enable_bit;

   modport source (
      output valid, mode, entry_index, entry_freq, entry_duration,
             seq_length, tempo_num, tempo_den, enable_bit,
      input  ready
   );

   modport sink (
      input  valid, mode, entry_index, entry_freq, entry_duration,
             seq_length, tempo_num, tempo_den, enable_bit,
      output ready
   );
endinterface

// Response channel: player status after each request.
interface tsp_rsp_if;
   import tsp_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [FREQ_W-1:0]     tone_freq;
   logic                  is_playing;
   logic                  sound_enabled;
   logic [STEP_OUT_W-1:0] current_step;
   logic                  sequence_done;

   modport source (
      output valid, tone_freq, is_playing, sound_enabled, current_step,
             sequence_done,
      input  ready
   );

   modport sink (
      input  valid, tone_freq, is_playing, sound_enabled, current_step,
             sequence_done,
      output ready
   );
endinterface

`default_nettype wire

[rtl/tsp_divider.sv]
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module tsp_divider (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [tsp_pkg::PROD_W-1:0] dividend,
   input  wire logic [tsp_pkg::DUR_W-1:0]  divisor,
   output logic                            done,
   output logic [tsp_pkg::PROD_W-1:0]      quotient
);
   import tsp_pkg::*;

   logic [DUR_W-1:0]  rem_ff, rem_in;
   logic [PROD_W-1:0] quo_ff, quo_in;
   logic [DUR_W-1:0]  div_ff, div_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DUR_W:0]    shifted;
   logic [DUR_W+1:0]  diff;
   logic              fits;

   // One shift and trial subtract of the partial remainder.
   always_comb begin
      shifted = {rem_ff, quo_ff[PROD_W-1]};
      diff    = {1'b0, shifted} - {2'b00, div_ff};
      fits    = ~diff[DUR_W+1];
   end

   // Iteration control.
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
         cnt_in  = DCNT_W'(DIV_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DUR_W-1:0] : shifted[DUR_W-1:0];
         quo_in = {quo_ff[PROD_W-2:0], fits};
         cnt_in = cnt_ff - DCNT_W'(1);
         if (cnt_ff == DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

[rtl/tone_sequence_player.sv]
`timescale 1ns / 1ps
`default_nettype none

// Buzzer tone sequence player.
// Requests arrive on req_chan: load a table step, play, stop, a millisecond
// tick, or set the sound enable. Every request produces exactly one response
// on rsp_chan with the tone to drive, the playing and enable flags, the step
// being played and a flag set on the tick that finished the last step.
// The step table is a 64 x 32 synchronous memory whose read data arrives in the
// cycle after the address is presented; all other state sits in registers.
// One request is worked at a time. Load, stop and enable go from the execute
// state straight to the finish state; a play also reads the first step's tone.
// A tick while playing scales the step duration by the tempo fraction through a
// multiply and the 32-iteration divider, then compares it with the elapsed
// time and, on a step change, reads the next step's tone.
// A new request is accepted while the previous response still waits in the
// output register. When the receiver stalls, the finished response of the
// next request waits until the output register is free.
// Reset (synchronous) stops playback, sets the enable flag and the tempo to
// 5/6. The table keeps its contents and holds nothing valid until loaded.
module tone_sequence_player (
   input wire logic  clock,
   input wire logic  reset,
   tsp_req_if.sink   req_chan,
   tsp_rsp_if.source rsp_chan
);
   import tsp_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_EXEC      = 9'b000000010,
      ST_MUL       = 9'b000000100,
      ST_DIV_GO    = 9'b000001000,
      ST_DIV_WAIT  = 9'b000010000,
      ST_CMP       = 9'b000100000,
      ST_FREQ_WAIT = 9'b001000000,
      ST_TONE      = 9'b010000000,
      ST_FINISH    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // Latched request.
   mode_type             cmd_mode_ff, cmd_mode_in;
   logic [ENTRY_W-1:0]   cmd_idx_ff, cmd_idx_in;
   logic [FREQ_W-1:0]    cmd_freq_ff, cmd_freq_in;
   logic [DUR_W-1:0]     cmd_dur_ff, cmd_dur_in;
   logic [SEQ_LEN_W-1:0] cmd_len_ff, cmd_len_in;
   logic [TEMPO_W-1:0]   cmd_num_ff, cmd_num_in;
   logic [TEMPO_W-1:0]   cmd_den_ff, cmd_den_in;
   logic                 cmd_en_ff, cmd_en_in;

   // Player state.
   logic                 playing_ff, playing_in;
   logic                 enabled_ff, enabled_in;
   logic [LEN_W-1:0]     ptr_ff, ptr_in;
   logic [LEN_W-1:0]     length_ff, length_in;
   logic [TEMPO_W-1:0]   num_ff, num_in;
   logic [TEMPO_W-1:0]   den_ff, den_in;
   logic [DUR_W-1:0]     elapsed_ff, elapsed_in;
   logic [FREQ_W-1:0]    tone_ff, tone_in;
   logic                 done_ff, done_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;

   // Response register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FREQ_W-1:0]     rsp_tone_ff, rsp_tone_in;
   logic                  rsp_playing_ff, rsp_playing_in;
   logic                  rsp_enabled_ff, rsp_enabled_in;
   logic [STEP_OUT_W-1:0] rsp_step_ff, rsp_step_in;
   logic                  rsp_done_ff, rsp_done_in;

   // Step table memory.
   logic [ENTRY_DATA_W-1:0] step_mem [STEP_DEPTH];
   logic [ENTRY_DATA_W-1:0] rd_data_ff;
   logic                    mem_we;
   logic [IDX_W-1:0]        mem_waddr;
   logic [IDX_W-1:0]        mem_raddr;

   // Divider link.
   logic                 div_start;
   logic                 div_done;
   logic [PROD_W-1:0]    div_quotient;
   logic [DUR_W-1:0]     scaled_dur;
   logic                 accept;
   logic                 rsp_free;
   logic [LEN_W-1:0]     ptr_next;

   tsp_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // The table is read at the step pointer on every cycle.
   assign mem_raddr = ptr_ff[IDX_W-1:0];
   assign mem_waddr = IDX_W'(cmd_idx_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         step_mem[mem_waddr] <= {cmd_freq_ff, cmd_dur_ff};
      end
      rd_data_ff <= step_mem[mem_raddr];
   end

   assign accept     = req_chan.valid && req_chan.ready;
   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;
   assign div_start  = (state_ff == ST_DIV_GO);
   assign scaled_dur = (div_quotient[DUR_W-1:0] == '0) ? DUR_W'(1)
                                                       : div_quotient[DUR_W-1:0];
   assign ptr_next   = ptr_ff + LEN_W'(1);

   // Request latch.
   always_comb begin
      cmd_mode_in = cmd_mode_ff;
      cmd_idx_in  = cmd_idx_ff;
      cmd_freq_in = cmd_freq_ff;
      cmd_dur_in  = cmd_dur_ff;
      cmd_len_in  = cmd_len_ff;
      cmd_num_in  = cmd_num_ff;
      cmd_den_in  = cmd_den_ff;
      cmd_en_in   = cmd_en_ff;
      if (accept) begin
         cmd_mode_in = mode_type'(req_chan.mode);
         cmd_idx_in  = req_chan.entry_index;
         cmd_freq_in = req_chan.entry_freq;
         cmd_dur_in  = req_chan.entry_duration;
         cmd_len_in  = req_chan.seq_length;
         cmd_num_in  = req_chan.tempo_num;
         cmd_den_in  = req_chan.tempo_den;
         cmd_en_in   = req_chan.enable_bit;
      end
   end

   // Sequencer: execute the request, then scale, compare and advance.
   always_comb begin
      state_in   = state_ff;
      playing_in = playing_ff;
      enabled_in = enabled_ff;
      ptr_in     = ptr_ff;
      length_in  = length_ff;
      num_in     = num_ff;
      den_in     = den_ff;
      elapsed_in = elapsed_ff;
      tone_in    = tone_ff;
      done_in    = done_ff;
      prod_in    = prod_ff;
      mem_we     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               done_in  = 1'b0;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_FINISH;
            case (cmd_mode_ff)
               MODE_LOAD: begin
                  mem_we = (32'(cmd_idx_ff) < STEP_DEPTH);
               end
               MODE_PLAY: begin
                  if (cmd_len_ff == '0 || cmd_num_ff == '0 || cmd_den_ff == '0) begin
                     playing_in = 1'b0;
                     length_in  = '0;
                     ptr_in     = '0;
                     tone_in    = '0;
                  end else begin
                     length_in  = (32'(cmd_len_ff) > STEP_DEPTH) ? LEN_W'(STEP_DEPTH)
                                                                 : LEN_W'(cmd_len_ff);
                     ptr_in     = '0;
                     num_in     = cmd_num_ff;
                     den_in     = cmd_den_ff;
                     playing_in = 1'b1;
                     state_in   = ST_FREQ_WAIT;
                  end
               end
               MODE_STOP: begin
                  playing_in = 1'b0;
                  length_in  = '0;
                  ptr_in     = '0;
                  tone_in    = '0;
               end
               MODE_TICK: begin
                  if (playing_ff && ptr_ff < length_ff) begin
                     if (elapsed_ff != '1) begin
                        elapsed_in = elapsed_ff + DUR_W'(1);
                     end
                     state_in = ST_MUL;
                  end
               end
               MODE_ENABLE: begin
                  enabled_in = cmd_en_ff;
                  tone_in    = '0;
               end
               default: begin
               end
            endcase
         end
         ST_MUL: begin
            // Table data for the current step is ready here.
            prod_in  = PROD_W'(rd_data_ff[DUR_W-1:0]) * PROD_W'(num_ff);
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            state_in = ST_FINISH;
            if (elapsed_ff >= scaled_dur) begin
               if (ptr_next >= length_ff) begin
                  playing_in = 1'b0;
                  length_in  = '0;
                  ptr_in     = '0;
                  tone_in    = '0;
                  done_in    = 1'b1;
               end else begin
                  ptr_in   = ptr_next;
                  state_in = ST_FREQ_WAIT;
               end
            end
         end
         ST_FREQ_WAIT: begin
            state_in = ST_TONE;
         end
         ST_TONE: begin
            // Start of a step: drive its tone unless muted or a rest.
            tone_in    = enabled_ff ? rd_data_ff[ENTRY_DATA_W-1:DUR_W] : '0;
            elapsed_in = '0;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response register: loaded when a request finishes and the slot is free.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_tone_in    = rsp_tone_ff;
      rsp_playing_in = rsp_playing_ff;
      rsp_enabled_in = rsp_enabled_ff;
      rsp_step_in    = rsp_step_ff;
      rsp_done_in    = rsp_done_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_FINISH && rsp_free) begin
         rsp_valid_in   = 1'b1;
         rsp_tone_in    = tone_ff;
         rsp_playing_in = playing_ff;
         rsp_enabled_in = enabled_ff;
         rsp_step_in    = ptr_ff[STEP_OUT_W-1:0];
         rsp_done_in    = done_ff;
      end
   end

   always_ff @(posedge clock) begin
      cmd_mode_ff    <= cmd_mode_in;
      cmd_idx_ff     <= cmd_idx_in;
      cmd_freq_ff    <= cmd_freq_in;
      cmd_dur_ff     <= cmd_dur_in;
      cmd_len_ff     <= cmd_len_in;
      cmd_num_ff     <= cmd_num_in;
      cmd_den_ff     <= cmd_den_in;
      cmd_en_ff      <= cmd_en_in;
      prod_ff        <= prod_in;
      rsp_tone_ff    <= rsp_tone_in;
      rsp_playing_ff <= rsp_playing_in;
      rsp_enabled_ff <= rsp_enabled_in;
      rsp_step_ff    <= rsp_step_in;
      rsp_done_ff    <= rsp_done_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         playing_ff   <= 1'b0;
         enabled_ff   <= 1'b1;
         ptr_ff       <= '0;
         length_ff    <= '0;
         num_ff       <= TEMPO_NUM_RST;
         den_ff       <= TEMPO_DEN_RST;
         elapsed_ff   <= '0;
         tone_ff      <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         playing_ff   <= playing_in;
         enabled_ff   <= enabled_in;
         ptr_ff       <= ptr_in;
         length_ff    <= length_in;
         num_ff       <= num_in;
         den_ff       <= den_in;
         elapsed_ff   <= elapsed_in;
         tone_ff      <= tone_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Port drive.
   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.tone_freq     = rsp_tone_ff;
   assign rsp_chan.is_playing    = rsp_playing_ff;
   assign rsp_chan.sound_enabled = rsp_enabled_ff;
   assign rsp_chan.current_step  = rsp_step_ff;
   assign rsp_chan.sequence_done = rsp_done_ff;

endmodule

`default_nettype wire

[rtl/tsp_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks of the player's responses.
module tsp_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic [tsp_pkg::FREQ_W-1:0]         rsp_tone_freq,
   input wire logic                               rsp_is_playing,
   input wire logic                               rsp_sound_enabled,
   input wire logic [tsp_pkg::STEP_OUT_W-1:0]     rsp_current_step,
   input wire logic                               rsp_sequence_done
);
   import tsp_pkg::*;

   // A pending response is held until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   // Reset leaves no response pending.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // An idle player reports step zero and silence.
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_playing |-> rsp_current_step == '0 && rsp_tone_freq == '0)
      else $error("idle player reports a step or a tone");

   // A finished sequence is no longer playing.
   a_done_stopped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sequence_done |-> !rsp_is_playing)
      else $error("sequence done while still playing");

   // Sound disabled means no tone.
   a_muted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_sound_enabled |-> rsp_tone_freq == '0)
      else $error("tone driven while sound is disabled");

endmodule

bind tone_sequence_player tsp_checker u_tsp_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_tone_freq     (rsp_chan.tone_freq),
   .rsp_is_playing    (rsp_chan.is_playing),
   .rsp_sound_enabled (rsp_chan.sound_enabled),
   .rsp_current_step  (rsp_chan.current_step),
   .rsp_sequence_done (rsp_chan.sequence_done)
);

`default_nettype wire
